/* src/scan_to_occupancy_grid_macros.svh */
// Assertion helpers for the checker of the occupancy grid block.
`ifndef SCAN_TO_OCCUPANCY_GRID_MACROS_SVH
`define SCAN_TO_OCCUPANCY_GRID_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SOG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("occupancy grid check failed");

// Consequent must hold in the cycle after the antecedent.
`define SOG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("occupancy grid check failed");

`endif

/* src/sog_pkg.sv */
package sog_pkg;

    // Default sizes of the map and of a scan.
    localparam int MAP_CELLS_DEF = 64;
    localparam int MAX_BEAMS_DEF = 2048;

    // Field widths.
    localparam int IDX_W      = 11;
    localparam int RANGE_W    = 16;
    localparam int ANG_W      = 16;
    localparam int CELL_W     = 12;
    localparam int OUT_CELL_W = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // CORDIC datapath.
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_CNT_W   = 4;
    localparam int XY_W         = 20;
    localparam int Z_W          = 25;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 20'sd39796;

    // Point and quotient widths: the point is Q16, the quotient works on its integer part.
    localparam int PROD_W = 40;
    localparam int QUO_W  = PROD_W - 16;

    // Scan epochs kept in the grid memory; zero marks a cell never set.
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'd255;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_ANGLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_ANGLE, S_CGO, S_CORDIC, S_MULX, S_MULY,
        S_DIVGO, S_DIV, S_CHECK, S_RD, S_UPD, S_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic rd;
        logic wr;
    } t_grid_req;

    typedef struct packed {
        logic busy;
        logic hit;
    } t_grid_rsp;

    // Arctangent of 2^-i in units of 1/2^24 turn, rounded.
    function automatic logic signed [Z_W-1:0] atan_turn24(input logic [STEP_CNT_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            4'd0:    v = 25'sd2097152;
            4'd1:    v = 25'sd1238021;
            4'd2:    v = 25'sd654136;
            4'd3:    v = 25'sd332049;
            4'd4:    v = 25'sd166669;
            4'd5:    v = 25'sd83416;
            4'd6:    v = 25'sd41718;
            4'd7:    v = 25'sd20860;
            4'd8:    v = 25'sd10430;
            4'd9:    v = 25'sd5215;
            4'd10:   v = 25'sd2608;
            4'd11:   v = 25'sd1304;
            4'd12:   v = 25'sd652;
            4'd13:   v = 25'sd326;
            4'd14:   v = 25'sd163;
            default: v = 25'sd81;
        endcase
        return v;
    endfunction

endpackage

/* src/sog_if.sv */
// Beam channel.
interface sog_beam_if;
    logic                          valid;
    logic                          ready;
    logic                          first_of_scan;
    logic [sog_pkg::IDX_W-1:0]     beam_index;
    logic [sog_pkg::RANGE_W-1:0]   range_mm;
    logic                          range_finite;
    modport source(output valid, first_of_scan, beam_index, range_mm, range_finite,
                   input ready);
    modport sink(input valid, first_of_scan, beam_index, range_mm, range_finite,
                 output ready);
endinterface

// Result channel.
interface sog_result_if;
    logic                            valid;
    logic                            ready;
    logic                            in_map;
    logic [sog_pkg::OUT_CELL_W-1:0]  cell_x;
    logic [sog_pkg::OUT_CELL_W-1:0]  cell_y;
    logic                            newly_marked;
    modport source(output valid, in_map, cell_x, cell_y, newly_marked, input ready);
    modport sink(input valid, in_map, cell_x, cell_y, newly_marked, output ready);
endinterface

// Register write channel.
interface sog_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sog_pkg::CFG_IDX_W-1:0]   index;
    logic [sog_pkg::CFG_DATA_W-1:0]  data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* src/sog_cordic.sv */
module sog_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [sog_pkg::ANG_W-1:0]         i_angle,
    output logic                              o_done,
    output logic signed [sog_pkg::XY_W-1:0]   o_cos,
    output logic signed [sog_pkg::XY_W-1:0]   o_sin
);

    logic                               r_busy, r_done;
    logic [sog_pkg::STEP_CNT_W-1:0]     r_cnt;
    logic signed [sog_pkg::XY_W-1:0]    r_x, r_y;
    logic signed [sog_pkg::Z_W-1:0]     r_z;
    logic                               r_flip;

    logic [sog_pkg::ANG_W-1:0]          w_quarter, w_fold;
    logic                               w_flip;
    logic signed [sog_pkg::XY_W-1:0]    w_dx, w_dy;

    // Fold the angle into the right half plane; the far half is flipped.
    always_comb begin
        w_quarter = i_angle + 16'h4000;
        w_flip    = w_quarter[sog_pkg::ANG_W-1];
        w_fold    = w_flip ? (i_angle ^ 16'h8000) : i_angle;
    end

    assign w_dx = r_y >>> r_cnt;
    assign w_dy = r_x >>> r_cnt;

    // Control: one rotation step per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == sog_pkg::STEP_CNT_W'(sog_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Rotation datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= sog_pkg::CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= {w_fold[sog_pkg::ANG_W-1], w_fold, 8'd0};
            r_flip <= w_flip;
        end else if (r_busy) begin
            if (!r_z[sog_pkg::Z_W-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - sog_pkg::atan_turn24(r_cnt);
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + sog_pkg::atan_turn24(r_cnt);
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

/* src/sog_divider.sv */
module sog_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sog_pkg::QUO_W-1:0]     i_dividend,
    input  logic [sog_pkg::CELL_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [sog_pkg::QUO_W-1:0]     o_quotient
);

    localparam int CNT_W = $clog2(sog_pkg::QUO_W);

    logic                         r_busy, r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [sog_pkg::CELL_W-1:0]   r_rem, r_div;
    logic [sog_pkg::QUO_W-1:0]    r_quo;
    logic [sog_pkg::CELL_W:0]     w_shift, w_diff;
    logic                         w_fit;

    // One restoring step: bring down the next dividend bit.
    always_comb begin
        w_shift = {r_rem, r_quo[sog_pkg::QUO_W-1]};
        w_fit   = (w_shift >= {1'b0, r_div});
        w_diff  = w_shift - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(sog_pkg::QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[sog_pkg::CELL_W-1:0] : w_shift[sog_pkg::CELL_W-1:0];
            r_quo <= {r_quo[sog_pkg::QUO_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* src/sog_grid.sv */
module sog_grid #(
    parameter int MAP_CELLS = sog_pkg::MAP_CELLS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  sog_pkg::t_grid_req                        i_req,
    input  logic [$clog2(MAP_CELLS*MAP_CELLS)-1:0]    i_addr,
    output sog_pkg::t_grid_rsp                        o_rsp
);

    localparam int DEPTH = MAP_CELLS * MAP_CELLS;
    localparam int AW    = $clog2(DEPTH);

    // Each cell holds the epoch of the scan that last marked it.
    logic [sog_pkg::EPOCH_W-1:0]  r_mem [DEPTH];
    logic [sog_pkg::EPOCH_W-1:0]  r_rdata;
    logic [sog_pkg::EPOCH_W-1:0]  r_epoch;
    logic                         r_clearing;
    logic [AW-1:0]                r_clr_addr;

    // Epoch and clearing pass control. A pass runs after reset and when epochs run out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_epoch    <= sog_pkg::EPOCH_FIRST;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
                r_epoch    <= sog_pkg::EPOCH_FIRST;
            end
        end else if (i_req.clear) begin
            if (r_epoch == sog_pkg::EPOCH_LAST) begin
                r_clearing <= 1'b1;
                r_clr_addr <= '0;
            end else begin
                r_epoch <= r_epoch + 1'b1;
            end
        end
    end

    // Write port.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.wr) begin
            r_mem[i_addr] <= r_epoch;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rsp.busy = r_clearing;
    assign o_rsp.hit  = (r_rdata == r_epoch);

endmodule

/* src/scan_to_occupancy_grid.sv */
// Lidar beam to occupancy grid projector.
// Beams enter on i_beam (valid/ready); one result word per beam leaves on
// o_result. Registers are written on i_cfg (index, data), which is always ready.
// A beam is handled alone: accepted, then its angle, a 16-step iterative CORDIC,
// two shared multiplies, two 24-step iterative dividers and a read-modify-write
// of the grid memory. The result is loaded into the output register, and the
// next beam can be taken in the cycle after; a new beam is never taken before
// the last one's result is loaded, and the CORDIC and divider iterations set the pace.
// A dropped beam skips the arithmetic. The grid memory stores a scan epoch per
// cell; a first-of-scan beam advances the epoch. After reset, and at every 255th
// first-of-scan beam, a clearing pass sweeps all MAP_CELLS*MAP_CELLS cells
// (4096 by default) of the memory while i_beam is held not ready. Reset returns
// the registers to their defaults. The result sits in an output register; if the
// receiver stalls, it holds there and the next beam is still accepted and worked
// on up to its result.
module scan_to_occupancy_grid #(
    parameter int MAP_CELLS = sog_pkg::MAP_CELLS_DEF,
    parameter int MAX_BEAMS = sog_pkg::MAX_BEAMS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sog_beam_if.sink             i_beam,
    sog_result_if.source         o_result,
    sog_cfg_if.sink              i_cfg
);

    localparam int CW = $clog2(MAP_CELLS);
    localparam int AW = $clog2(MAP_CELLS * MAP_CELLS);

    sog_pkg::t_state  r_state, n_state;

    // Configuration registers.
    logic [sog_pkg::ANG_W-1:0]    r_start, r_step;
    logic [sog_pkg::RANGE_W-1:0]  r_min, r_max;
    logic [sog_pkg::CELL_W-1:0]   r_cell;

    // Beam and working registers.
    logic [sog_pkg::IDX_W-1:0]         r_idx;
    logic [sog_pkg::RANGE_W-1:0]       r_range;
    logic                              r_finite;
    logic [sog_pkg::ANG_W-1:0]         r_ang;
    logic                              r_drop;
    logic signed [sog_pkg::XY_W-1:0]   r_cos, r_sin;
    logic signed [sog_pkg::PROD_W-1:0] r_prod_x, r_prod_y;
    logic                              r_neg_x, r_neg_y;
    logic [CW-1:0]                     r_px, r_py;
    logic                              r_inmap, r_newly;

    // Output register.
    logic                              r_ov, r_o_inmap, r_o_newly;
    logic [sog_pkg::OUT_CELL_W-1:0]    r_o_x, r_o_y;

    sog_pkg::t_grid_req  w_greq;
    sog_pkg::t_grid_rsp  w_grsp;
    logic [AW-1:0]       w_addr;

    logic                              w_accept, w_cstart, w_dstart, w_load;
    logic                              w_cdone, w_dxdone, w_dydone;
    logic signed [sog_pkg::XY_W-1:0]   w_cos, w_sin;
    logic [sog_pkg::CELL_W-1:0]        w_cell;
    logic signed [sog_pkg::XY_W-1:0]   w_mul_b;
    logic signed [sog_pkg::PROD_W-1:0] w_prod, w_offset, w_nx, w_ny, w_mx, w_my;
    logic [sog_pkg::QUO_W-1:0]         w_qx, w_qy;
    logic                              w_inx, w_iny;

    assign w_accept = i_beam.valid && i_beam.ready;

    // Register writes; unknown indexes are ignored.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 16'h8000;
            r_step  <= 16'd32;
            r_min   <= 16'd100;
            r_max   <= 16'd12000;
            r_cell  <= 12'd50;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sog_pkg::CFG_START_ANGLE: r_start <= i_cfg.data;
                sog_pkg::CFG_STEP_ANGLE:  r_step  <= i_cfg.data;
                sog_pkg::CFG_MIN_RANGE:   r_min   <= i_cfg.data;
                sog_pkg::CFG_MAX_RANGE:   r_max   <= i_cfg.data;
                sog_pkg::CFG_CELL_SIZE:   r_cell  <= i_cfg.data[sog_pkg::CELL_W-1:0];
                default: ;
            endcase
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sog_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sog_pkg::S_IDLE:   if (w_accept) n_state = i_beam.first_of_scan ? sog_pkg::S_CLEAR
                                                                            : sog_pkg::S_ANGLE;
            sog_pkg::S_CLEAR:  if (!w_grsp.busy) n_state = sog_pkg::S_ANGLE;
            sog_pkg::S_ANGLE:  n_state = sog_pkg::S_CGO;
            sog_pkg::S_CGO:    n_state = r_drop ? sog_pkg::S_OUT : sog_pkg::S_CORDIC;
            sog_pkg::S_CORDIC: if (w_cdone) n_state = sog_pkg::S_MULX;
            sog_pkg::S_MULX:   n_state = sog_pkg::S_MULY;
            sog_pkg::S_MULY:   n_state = sog_pkg::S_DIVGO;
            sog_pkg::S_DIVGO:  n_state = sog_pkg::S_DIV;
            sog_pkg::S_DIV:    if (w_dxdone && w_dydone) n_state = sog_pkg::S_CHECK;
            sog_pkg::S_CHECK:  n_state = r_inmap ? sog_pkg::S_RD : sog_pkg::S_OUT;
            sog_pkg::S_RD:     n_state = sog_pkg::S_UPD;
            sog_pkg::S_UPD:    n_state = sog_pkg::S_OUT;
            sog_pkg::S_OUT:    if (w_load) n_state = sog_pkg::S_IDLE;
            default:           n_state = sog_pkg::S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        i_beam.ready = 1'b0;
        w_greq       = '0;
        w_cstart     = 1'b0;
        w_dstart     = 1'b0;
        w_load       = 1'b0;
        case (r_state)
            sog_pkg::S_IDLE: begin
                i_beam.ready = !w_grsp.busy;
                w_greq.clear = i_beam.valid && !w_grsp.busy && i_beam.first_of_scan;
            end
            sog_pkg::S_CGO:   w_cstart   = !r_drop;
            sog_pkg::S_DIVGO: w_dstart   = 1'b1;
            sog_pkg::S_RD:    w_greq.rd  = 1'b1;
            sog_pkg::S_UPD:   w_greq.wr  = 1'b1;
            sog_pkg::S_OUT:   w_load     = !r_ov || o_result.ready;
            default: ;
        endcase
    end

    // Datapath helpers.
    always_comb begin
        w_cell   = (r_cell == '0) ? sog_pkg::CELL_W'(1) : r_cell;
        w_mul_b  = (r_state == sog_pkg::S_MULX) ? r_cos : r_sin;
        w_prod   = sog_pkg::PROD_W'($signed({1'b0, r_range})) * sog_pkg::PROD_W'(w_mul_b);
        w_offset = $signed((sog_pkg::PROD_W'(w_cell) * sog_pkg::PROD_W'(MAP_CELLS / 2)) << 16);
        w_nx     = r_prod_x + w_offset;
        w_ny     = r_prod_y + w_offset;
        w_mx     = w_nx[sog_pkg::PROD_W-1] ? -w_nx : w_nx;
        w_my     = w_ny[sog_pkg::PROD_W-1] ? -w_ny : w_ny;
        // A negative coordinate above minus one cell truncates to cell zero.
        w_inx    = r_neg_x ? (w_qx == '0) : (w_qx < sog_pkg::QUO_W'(MAP_CELLS));
        w_iny    = r_neg_y ? (w_qy == '0) : (w_qy < sog_pkg::QUO_W'(MAP_CELLS));
        w_addr   = AW'(32'(r_py) * MAP_CELLS + 32'(r_px));
    end

    // Working registers, advanced by the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            sog_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_idx    <= i_beam.beam_index;
                    r_range  <= i_beam.range_mm;
                    r_finite <= i_beam.range_finite;
                end
            end
            sog_pkg::S_ANGLE: begin
                r_ang   <= r_start + sog_pkg::ANG_W'(r_idx * r_step);
                r_drop  <= !r_finite || (32'(r_idx) >= MAX_BEAMS) ||
                           (r_range < r_min) || (r_range > r_max);
                r_inmap <= 1'b0;
                r_newly <= 1'b0;
            end
            sog_pkg::S_CORDIC: begin
                if (w_cdone) begin
                    r_cos <= w_cos;
                    r_sin <= w_sin;
                end
            end
            sog_pkg::S_MULX:  r_prod_x <= w_prod;
            sog_pkg::S_MULY:  r_prod_y <= w_prod;
            sog_pkg::S_DIVGO: begin
                r_neg_x <= w_nx[sog_pkg::PROD_W-1];
                r_neg_y <= w_ny[sog_pkg::PROD_W-1];
            end
            sog_pkg::S_DIV: begin
                if (w_dxdone && w_dydone) begin
                    r_px    <= r_neg_x ? '0 : w_qx[CW-1:0];
                    r_py    <= r_neg_y ? '0 : w_qy[CW-1:0];
                    r_inmap <= w_inx && w_iny;
                end
            end
            sog_pkg::S_UPD:   r_newly <= !w_grsp.hit;
            default: ;
        endcase
    end

    // Output register: holds a finished word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_result.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_inmap <= r_inmap;
            r_o_x     <= r_inmap ? sog_pkg::OUT_CELL_W'(r_px) : '0;
            r_o_y     <= r_inmap ? sog_pkg::OUT_CELL_W'(r_py) : '0;
            r_o_newly <= r_inmap && r_newly;
        end
    end

    assign o_result.valid        = r_ov;
    assign o_result.in_map       = r_o_inmap;
    assign o_result.cell_x       = r_o_x;
    assign o_result.cell_y       = r_o_y;
    assign o_result.newly_marked = r_o_newly;

    sog_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_angle (r_ang),
        .o_done  (w_cdone),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    sog_divider u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_mx[sog_pkg::PROD_W-1:16]),
        .i_divisor  (w_cell),
        .o_done     (w_dxdone),
        .o_quotient (w_qx)
    );

    sog_divider u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_my[sog_pkg::PROD_W-1:16]),
        .i_divisor  (w_cell),
        .o_done     (w_dydone),
        .o_quotient (w_qy)
    );

    sog_grid #(
        .MAP_CELLS (MAP_CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_greq),
        .i_addr  (w_addr),
        .o_rsp   (w_grsp)
    );

endmodule

/* src/sog_checker.sv */
`include "scan_to_occupancy_grid_macros.svh"

module sog_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic                               i_in_map,
    input logic [sog_pkg::OUT_CELL_W-1:0]     i_cell_x,
    input logic [sog_pkg::OUT_CELL_W-1:0]     i_cell_y,
    input logic                               i_newly
);

    // Beams are handled one at a time.
    `SOG_ASSERT_NEXT(a_one_beam, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // No result can appear the cycle after a beam is taken.
    `SOG_ASSERT_NEXT(a_min_latency, i_clk, i_rst_n, i_in_valid && i_in_ready, !$rose(i_out_valid))

    // A word outside the map carries no cell and no mark.
    `SOG_ASSERT_IMPL(a_off_map_zero, i_clk, i_rst_n, i_out_valid && !i_in_map, (i_cell_x == '0) && (i_cell_y == '0) && !i_newly)

    // A stalled word stays put.
    `SOG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_cell_x) && $stable(i_cell_y) && $stable(i_newly))

endmodule

bind scan_to_occupancy_grid sog_checker u_sog_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_beam.valid),
    .i_in_ready  (i_beam.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_in_map    (o_result.in_map),
    .i_cell_x    (o_result.cell_x),
    .i_cell_y    (o_result.cell_y),
    .i_newly     (o_result.newly_marked)
);
